FILE: rtl/fcull_pkg.sv
package fcull_pkg;

    // fixed geometry of the block
    localparam int MAX_PLANES  = 6;
    localparam int COORD_BITS  = 16;
    localparam int NORM_BITS   = 16;
    localparam int PLANE_BITS  = 64;
    localparam int FRAC_SHIFT  = 14;

    // query kinds
    localparam logic [1:0] FUNC_BOX    = 2'd0;
    localparam logic [1:0] FUNC_SPHERE = 2'd1;
    localparam logic [1:0] FUNC_POINT  = 2'd2;

    // register map
    localparam int REG_INDEX_W = $clog2(MAX_PLANES + 1);
    localparam logic [REG_INDEX_W-1:0] REG_PLANE_COUNT = REG_INDEX_W'(0);
    localparam logic [REG_INDEX_W-1:0] REG_PLANE_0     = REG_INDEX_W'(1);
    localparam int COUNT_W = 3;

    // datapath widths
    localparam int PROD_W   = COORD_BITS + NORM_BITS;
    localparam int REACH_W  = COORD_BITS + NORM_BITS + 2;
    localparam int WIDE_IN  = (COORD_BITS > NORM_BITS) ? COORD_BITS : NORM_BITS;
    localparam int ACC_W    = WIDE_IN + FRAC_SHIFT + 6;

    // stream payload widths
    localparam int S_FIELDS  = 7;
    localparam int S_TDATA_W = ((S_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;
    localparam int TUSER_W   = 2;

    // plane field positions
    localparam int NX_LSB = 0;
    localparam int NY_LSB = 16;
    localparam int NZ_LSB = 32;
    localparam int D_LSB  = 48;

    typedef logic [PLANE_BITS-1:0] plane_t;

    // control shared by every plane lane
    typedef struct packed {
        logic en_prod;
        logic en_cmp;
        logic is_box;
    } lane_ctl_t;

endpackage

FILE: rtl/fcull_cfg.sv
module fcull_cfg
    import fcull_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [PLANE_BITS-1:0]  cfg_wdata,
    output logic [COUNT_W-1:0]     plane_count_sat,
    output plane_t                 planes [MAX_PLANES]
);

    logic [COUNT_W-1:0] plane_count_reg;
    plane_t             plane_reg [MAX_PLANES];

    // register writes, unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_count_reg <= '0;
            for (int i = 0; i < MAX_PLANES; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == REG_PLANE_COUNT) begin
                plane_count_reg <= cfg_wdata[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_PLANES; i++) begin
                if (cfg_index == REG_PLANE_0 + REG_INDEX_W'(i)) begin
                    plane_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // count above the lane number saturates
    always_comb begin
        if (plane_count_reg > COUNT_W'(MAX_PLANES)) begin
            plane_count_sat = COUNT_W'(MAX_PLANES);
        end else begin
            plane_count_sat = plane_count_reg;
        end
    end

    assign planes = plane_reg;

endmodule

FILE: rtl/fcull_lane.sv
module fcull_lane
    import fcull_pkg::*;
(
    input  logic                         aclk,
    input  lane_ctl_t                    ctl,
    input  plane_t                       plane,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] cz,
    input  logic        [COORD_BITS:0]   hx_abs,
    input  logic        [COORD_BITS:0]   hy_abs,
    input  logic        [COORD_BITS:0]   hz_abs,
    input  logic signed [COORD_BITS-1:0] mg,
    output logic                         fail
);

    logic signed [NORM_BITS-1:0] nx, ny, nz, d;
    logic        [NORM_BITS:0]   nx_abs, ny_abs, nz_abs;
    logic signed [NORM_BITS:0]   nx_ext, ny_ext, nz_ext;

    logic signed [PROD_W-1:0]  pcx_next, pcy_next, pcz_next;
    logic signed [PROD_W-1:0]  pcx_reg, pcy_reg, pcz_reg;
    logic        [REACH_W-1:0] phx_next, phy_next, phz_next;
    logic        [REACH_W-1:0] phx_reg, phy_reg, phz_reg;

    logic signed [ACC_W-1:0] sdist, reach, slack;
    logic                    fail_reg;

    // unpack the plane
    assign nx = plane[NX_LSB +: NORM_BITS];
    assign ny = plane[NY_LSB +: NORM_BITS];
    assign nz = plane[NZ_LSB +: NORM_BITS];
    assign d  = plane[D_LSB  +: NORM_BITS];

    // normal magnitudes, the most negative value keeps its full size
    assign nx_ext = (NORM_BITS+1)'(nx);
    assign ny_ext = (NORM_BITS+1)'(ny);
    assign nz_ext = (NORM_BITS+1)'(nz);
    assign nx_abs = nx_ext[NORM_BITS] ? -nx_ext : nx_ext;
    assign ny_abs = ny_ext[NORM_BITS] ? -ny_ext : ny_ext;
    assign nz_abs = nz_ext[NORM_BITS] ? -nz_ext : nz_ext;

    // center and extent products
    assign pcx_next = PROD_W'(cx) * PROD_W'(nx);
    assign pcy_next = PROD_W'(cy) * PROD_W'(ny);
    assign pcz_next = PROD_W'(cz) * PROD_W'(nz);
    assign phx_next = REACH_W'(hx_abs) * REACH_W'(nx_abs);
    assign phy_next = REACH_W'(hy_abs) * REACH_W'(ny_abs);
    assign phz_next = REACH_W'(hz_abs) * REACH_W'(nz_abs);

    always_ff @(posedge aclk) begin
        if (ctl.en_prod) begin
            pcx_reg <= pcx_next;
            pcy_reg <= pcy_next;
            pcz_reg <= pcz_next;
            phx_reg <= phx_next;
            phy_reg <= phy_next;
            phz_reg <= phz_next;
        end
    end

    // signed distance plus reach, negative means outside this plane
    always_comb begin
        sdist = ACC_W'(pcx_reg) + ACC_W'(pcy_reg) + ACC_W'(pcz_reg)
              - (ACC_W'(d) <<< FRAC_SHIFT);
        if (ctl.is_box) begin
            reach = $signed(ACC_W'(phx_reg)) + $signed(ACC_W'(phy_reg))
                  + $signed(ACC_W'(phz_reg));
        end else begin
            reach = ACC_W'(mg) <<< FRAC_SHIFT;
        end
        slack = sdist + reach;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_cmp) begin
            fail_reg <= slack[ACC_W-1];
        end
    end

    assign fail = fail_reg;

endmodule

FILE: rtl/frustum_cull_tester_core.sv
// channel   | dir | tdata (low bit up)                         | tuser
// s_        | in  | center_x,center_y,center_z,half_x,half_y,   | func
//           |     | half_z,margin (16 bits each)               |
// m_        | out | inside_res, zero fill to 8 bits            | kind_echo
// cfg_      | in  | write only: plane_count, plane_0..plane_5  | -
//
// four register stages: input, products, per-plane compare, result
// one request per cycle sustained while m_tready stays high, through the input, products, compare and result registers
// the six plane lanes run in parallel, each with its own multipliers
// synchronous active-low reset clears the valid bits and the config registers
// a stall on m_tready fills the stages behind it before s_tready drops
module frustum_cull_tester_core
    import fcull_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [PLANE_BITS-1:0]  cfg_wdata,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, margin
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [TUSER_W-1:0]     s_tuser,
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // inside_res, zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    // kind_echo
    output logic [TUSER_W-1:0]     m_tuser
);

    localparam int CW = COORD_BITS;

    logic [COUNT_W-1:0] plane_count_sat;
    plane_t             planes [MAX_PLANES];

    logic en1, en2, en3, en_o;
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;

    logic        [TUSER_W-1:0] func1_reg, func2_reg, func3_reg;
    logic signed [CW-1:0]      cx_reg, cy_reg, cz_reg, hx_reg, hy_reg, hz_reg, mg1_reg;
    logic signed [CW-1:0]      mg2_reg;
    logic                      is_box_reg;
    logic signed [CW:0]        hx_ext, hy_ext, hz_ext;
    logic        [CW:0]        hx_abs, hy_abs, hz_abs;

    lane_ctl_t                 ctl;
    logic [MAX_PLANES-1:0]     fail, active;
    logic                      inside_next;
    logic                      inside_reg;
    logic [TUSER_W-1:0]        kind_reg;

    fcull_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .plane_count_sat (plane_count_sat),
        .planes          (planes)
    );

    // stage enables, each stage loads when empty or draining
    assign en_o     = !m_valid_reg || m_tready;
    assign en3      = !v3_reg || en_o;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1)  v1_reg      <= s_tvalid;
            if (en2)  v2_reg      <= v1_reg;
            if (en3)  v3_reg      <= v2_reg;
            if (en_o) m_valid_reg <= v3_reg;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (en1) begin
            func1_reg <= s_tuser;
            cx_reg    <= s_tdata[0*CW +: CW];
            cy_reg    <= s_tdata[1*CW +: CW];
            cz_reg    <= s_tdata[2*CW +: CW];
            hx_reg    <= s_tdata[3*CW +: CW];
            hy_reg    <= s_tdata[4*CW +: CW];
            hz_reg    <= s_tdata[5*CW +: CW];
            mg1_reg   <= s_tdata[6*CW +: CW];
        end
    end

    // half extent magnitudes
    assign hx_ext = (CW+1)'(hx_reg);
    assign hy_ext = (CW+1)'(hy_reg);
    assign hz_ext = (CW+1)'(hz_reg);
    assign hx_abs = hx_ext[CW] ? -hx_ext : hx_ext;
    assign hy_abs = hy_ext[CW] ? -hy_ext : hy_ext;
    assign hz_abs = hz_ext[CW] ? -hz_ext : hz_ext;

    // side band carried along with the products and compares
    always_ff @(posedge aclk) begin
        if (en2) begin
            func2_reg  <= func1_reg;
            mg2_reg    <= mg1_reg;
            is_box_reg <= (func1_reg == FUNC_BOX);
        end
        if (en3) begin
            func3_reg <= func2_reg;
        end
    end

    assign ctl.en_prod = en2;
    assign ctl.en_cmp  = en3;
    assign ctl.is_box  = is_box_reg;

    // one lane per plane
    for (genvar g = 0; g < MAX_PLANES; g++) begin : g_lane
        fcull_lane u_lane (
            .aclk   (aclk),
            .ctl    (ctl),
            .plane  (planes[g]),
            .cx     (cx_reg),
            .cy     (cy_reg),
            .cz     (cz_reg),
            .hx_abs (hx_abs),
            .hy_abs (hy_abs),
            .hz_abs (hz_abs),
            .mg     (mg2_reg),
            .fail   (fail[g])
        );
        assign active[g] = (COUNT_W'(g) < plane_count_sat);
    end

    // combine the active lanes
    assign inside_next = ~|(fail & active);

    always_ff @(posedge aclk) begin
        if (en_o) begin
            inside_reg <= inside_next;
            kind_reg   <= func3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(inside_reg);
    assign m_tuser  = kind_reg;

    // no active planes means the query passes
    a_no_planes_pass : assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && en_o && plane_count_sat == '0) |=> m_tdata[0])
        else $error("query failed with no active planes");

    // an empty result register never blocks the input
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // an accepted request lands in the input register
    a_accept_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted request lost at input register");

    // the saturated count never exceeds the lane count
    a_count_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        plane_count_sat <= COUNT_W'(MAX_PLANES))
        else $error("plane count above lane count");

endmodule

FILE: sim/cull_checker.sv
`timescale 1ns / 100ps

module cull_checker
    import fcull_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [PLANE_BITS-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, margin
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [TUSER_W-1:0]     s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // inside_res, zero fill
    input  logic [M_TDATA_W-1:0]   m_tdata,
    // kind_echo
    input  logic [TUSER_W-1:0]     m_tuser,
    output int                     fail_count,
    output int                     pending_count
);

    localparam longint FRAC_ONE = longint'(1) << FRAC_SHIFT;

    typedef struct packed {
        logic               pass_ok;
        logic [TUSER_W-1:0] kind;
    } verdict_t;

    // shadow copy of the register file
    logic [COUNT_W-1:0] active_planes = '0;
    plane_t             plane_regs [MAX_PLANES];

    verdict_t expected_verdicts [$];
    int       errors = 0;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // slot 0 is center_x, slot 6 is margin
    function automatic longint coord_field(input logic [S_TDATA_W-1:0] body, input int slot);
        return longint'($signed(body[slot*COORD_BITS +: COORD_BITS]));
    endfunction

    function automatic longint plane_field(input plane_t p, input int lsb);
        return longint'($signed(p[lsb +: NORM_BITS]));
    endfunction

    // exact fixed-point test of one request against the active planes
    function automatic logic judge_query(input logic [TUSER_W-1:0] kind,
                                         input logic [S_TDATA_W-1:0] body);
        longint cx, cy, cz, hx, hy, hz, mg;
        longint nx, ny, nz, d, sdist, reach;
        int     used;
        logic   pass;
        cx = coord_field(body, 0);
        cy = coord_field(body, 1);
        cz = coord_field(body, 2);
        hx = magnitude(coord_field(body, 3));
        hy = magnitude(coord_field(body, 4));
        hz = magnitude(coord_field(body, 5));
        mg = coord_field(body, 6) * FRAC_ONE;
        used = (active_planes > MAX_PLANES) ? MAX_PLANES : int'(active_planes);
        pass = 1'b1;
        for (int i = 0; i < used; i++) begin
            nx = plane_field(plane_regs[i], NX_LSB);
            ny = plane_field(plane_regs[i], NY_LSB);
            nz = plane_field(plane_regs[i], NZ_LSB);
            d  = plane_field(plane_regs[i], D_LSB) * FRAC_ONE;
            sdist = cx * nx + cy * ny + cz * nz - d;
            if (kind == FUNC_BOX) begin
                reach = hx * magnitude(nx) + hy * magnitude(ny) + hz * magnitude(nz);
            end else begin
                reach = mg;
            end
            if (sdist < -reach) begin
                pass = 1'b0;
            end
        end
        return pass;
    endfunction

    always @(posedge aclk) begin
        verdict_t fresh;
        verdict_t want;
        if (!aresetn) begin
            active_planes = '0;
            foreach (plane_regs[i]) plane_regs[i] = '0;
            expected_verdicts.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                if (cfg_index == REG_PLANE_COUNT) begin
                    active_planes = cfg_wdata[COUNT_W-1:0];
                end else if (cfg_index >= REG_PLANE_0 && cfg_index < REG_PLANE_0 + MAX_PLANES) begin
                    plane_regs[cfg_index - REG_PLANE_0] = cfg_wdata;
                end
            end
            // accepted request
            if (s_tvalid && s_tready) begin
                fresh.pass_ok = judge_query(s_tuser, s_tdata);
                fresh.kind    = s_tuser;
                expected_verdicts = {expected_verdicts, fresh};
            end
            // accepted result
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result with no request pending: inside_res %0d kind_echo %0d",
                           m_tdata[0], m_tuser);
                    errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want.pass_ok) begin
                        $error("inside_res mismatch: expected %0d, got %0d",
                               want.pass_ok, m_tdata[0]);
                        errors++;
                    end
                    if (m_tuser !== want.kind) begin
                        $error("kind_echo mismatch: expected %0d, got %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata[M_TDATA_W-1:1] !== '0) begin
                        $error("m_tdata fill mismatch: expected 0, got %0h",
                               m_tdata[M_TDATA_W-1:1]);
                        errors++;
                    end
                end
            end
        end
        fail_count    <= errors;
        pending_count <= expected_verdicts.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fcull_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [REG_INDEX_W-1:0] REG_UNMAPPED = REG_INDEX_W'(MAX_PLANES + 1);

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_QUERIES = 135;
    localparam int SETTLE_CYCLES = 12;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [REG_INDEX_W-1:0] cfg_index = '0;
    logic [PLANE_BITS-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [TUSER_W-1:0]     s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]     m_tuser;

    int fail_count;
    int pending_count;
    int cycles      = 0;
    int ready_run   = 0;
    int gap_pct     = 25;
    int stall_pct   = 25;
    bit steady      = 1'b0;

    frustum_cull_tester_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cull_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side backpressure in bursts
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            if (!steady && $urandom_range(0, 99) < stall_pct) begin
                m_tready  <= 1'b0;
                ready_run <= $urandom_range(0, 15);
            end else begin
                m_tready  <= 1'b1;
                ready_run <= $urandom_range(1, 24);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    task automatic write_reg(input logic [REG_INDEX_W-1:0] index, input logic [PLANE_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // one request, with an optional idle burst ahead of it
    task automatic send_query(input logic [1:0] kind,
                              input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] cz,
                              input logic [15:0] hx, input logic [15:0] hy, input logic [15:0] hz,
                              input logic [15:0] mg);
        if (!steady && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {mg, hz, hy, hx, cz, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // half the time full range, otherwise near the origin
    function automatic logic [15:0] pick_coord();
        if ($urandom_range(0, 1) == 1) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 4095) - 2048);
    endfunction

    function automatic logic [1:0] pick_kind();
        case ($urandom_range(0, 6))
            0, 1:    return FUNC_BOX;
            2, 3:    return FUNC_SPHERE;
            4, 5:    return FUNC_POINT;
            default: return FUNC_SPARE;
        endcase
    endfunction

    // random, roughly unit normal, or extreme plane
    function automatic logic [PLANE_BITS-1:0] pick_plane();
        logic [15:0] nx, ny, nz, d;
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1, 2: begin
                nx = 16'($urandom_range(0, 32768) - 16384);
                ny = 16'($urandom_range(0, 32768) - 16384);
                nz = 16'($urandom_range(0, 32768) - 16384);
                d  = 16'($urandom_range(0, 4095) - 2048);
                return {d, nz, ny, nx};
            end
            default: begin
                nx = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                ny = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                nz = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                d  = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                return {d, nz, ny, nx};
            end
        endcase
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no active planes after reset, everything passes
        send_query(FUNC_BOX, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_query(FUNC_POINT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        drain_results();

        // cube of +-1600 around the origin, d = -1600 on each face
        write_reg(REG_INDEX_W'(REG_PLANE_0 + 0), 64'hF9C0_0000_0000_4000);
        write_reg(REG_INDEX_W'(REG_PLANE_0 + 1), 64'hF9C0_0000_0000_C000);
        write_reg(REG_INDEX_W'(REG_PLANE_0 + 2), 64'hF9C0_0000_4000_0000);
        write_reg(REG_INDEX_W'(REG_PLANE_0 + 3), 64'hF9C0_0000_C000_0000);
        write_reg(REG_INDEX_W'(REG_PLANE_0 + 4), 64'hF9C0_4000_0000_0000);
        write_reg(REG_INDEX_W'(REG_PLANE_0 + 5), 64'hF9C0_C000_0000_0000);
        write_reg(REG_PLANE_COUNT, 64'd6);

        // points inside and outside the x = 1600 face, with and without expand
        send_query(FUNC_POINT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_query(FUNC_POINT, 16'd3200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_query(FUNC_POINT, 16'd3200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1600);
        send_query(FUNC_POINT, 16'd3201, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1600);
        // negative radius tightens the test
        send_query(FUNC_SPHERE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd1600);
        send_query(FUNC_SPHERE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd1601);
        // box on the boundary, negative and most negative half extents
        send_query(FUNC_BOX, 16'd3200, 16'd0, 16'd0, 16'd1600, 16'd0, 16'd0, 16'h8000);
        send_query(FUNC_BOX, 16'd3200, 16'd0, 16'd0, -16'sd1600, 16'd0, 16'd0, 16'h8000);
        send_query(FUNC_BOX, 16'd3200, 16'd0, 16'd0, 16'd1599, 16'd0, 16'd0, 16'h7FFF);
        send_query(FUNC_BOX, 16'h7FFF, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0);
        // half extents must not matter for a sphere
        send_query(FUNC_SPHERE, 16'd3200, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1600);
        // spare kind behaves as a point
        send_query(FUNC_SPARE, 16'd3200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1600);
        send_query(FUNC_SPARE, 16'd3200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1599);
        // field extremes
        send_query(FUNC_BOX, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_query(FUNC_SPHERE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        drain_results();

        // count above the maximum saturates, unmapped index is dropped
        write_reg(REG_PLANE_COUNT, 64'd7);
        write_reg(REG_UNMAPPED, 64'h7FFF_0000_0000_0000);
        send_query(FUNC_POINT, 16'd0, 16'd0, 16'd3200, 16'd0, 16'd0, 16'd0, 16'd0);
        send_query(FUNC_POINT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        drain_results();

        // only the first plane active
        write_reg(REG_PLANE_COUNT, 64'd1);
        send_query(FUNC_POINT, 16'd3200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_query(FUNC_POINT, -16'sd3200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        drain_results();

        // random phases, each with its own plane set
        for (int p = 0; p < PHASES; p++) begin
            steady    = (p == PHASES - 1);
            gap_pct   = (p % 3 == 1) ? 0 : 30;
            stall_pct = (p % 3 == 2) ? 0 : 30;
            write_reg(REG_PLANE_COUNT, 64'($urandom_range(0, 7)));
            for (int i = 0; i < MAX_PLANES; i++) begin
                if (p == 0 || $urandom_range(0, 1) == 1) begin
                    write_reg(REG_INDEX_W'(REG_PLANE_0 + i), pick_plane());
                end
            end
            repeat (PHASE_QUERIES) begin
                send_query(pick_kind(), pick_coord(), pick_coord(), pick_coord(),
                           pick_coord(), pick_coord(), pick_coord(), pick_coord());
            end
            drain_results();
        end

        // let any stray result show up
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: frustum_cull_tester_core.f
rtl/fcull_pkg.sv
rtl/fcull_cfg.sv
rtl/fcull_lane.sv
rtl/frustum_cull_tester_core.sv
sim/cull_checker.sv
sim/testbench.sv
